/* hdl/sitdt_pkg.sv */
// package for signed_int_to_decimal_text
// holds the sequencer state type, ascii codes and divide-by-ten constants
// no dependencies
package sitdt_pkg;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIG,
        S_EMIT
    } t_state;

    // ascii codes, trimmed to the 6-bit character port
    localparam logic [5:0] CH_ZERO  = 6'h30;
    localparam logic [5:0] CH_MINUS = 6'h2D;
    localparam logic [5:0] CH_SPACE = 6'h20;

    // reciprocal of ten: q = (n * 0xCCCCCCCD) >> 35 is exact for any n below 2^32
    localparam int          RECIP_BITS  = 32;
    localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT = 35;
    localparam int          RADIX       = 10;

endpackage

/* hdl/sitdt_div10.sv */
// shared divide-by-ten unit for signed_int_to_decimal_text
// registered reciprocal product; quotient and remainder are combinational from it
// depends on sitdt_pkg
module sitdt_div10 #(
    parameter int W = 16
) (
    input  logic         i_clk,
    input  logic         i_load,
    input  logic [W-1:0] i_dividend,
    output logic [W-1:0] o_quotient,
    output logic [3:0]   o_remainder
);
    import sitdt_pkg::*;

    localparam int PROD_W = W + RECIP_BITS;

    logic [PROD_W-1:0] r_prod;
    logic [W-1:0]      r_dividend;
    logic [W-1:0]      quot;
    logic [W-1:0]      back;
    logic [W-1:0]      diff;

    // multiply by the reciprocal, product registered
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod     <= PROD_W'(i_dividend) * PROD_W'(DIV10_RECIP);
            r_dividend <= i_dividend;
        end
    end

    // quotient from the high bits, remainder by shift-and-add back-multiply
    always_comb begin
        quot = W'(r_prod[PROD_W-1:DIV10_SHIFT]);
        back = W'(quot << 3) + W'(quot << 1);
        diff = r_dividend - back;
    end

    assign o_quotient  = quot;
    assign o_remainder = diff[3:0];

endmodule

/* hdl/signed_int_to_decimal_text.sv */
// signed_int_to_decimal_text: signed integer to right-justified decimal ascii text
// input item: one signed VALUE_BITS-bit value on i_value, valid/ready handshake
// output items: FIELD_CHARS characters, leftmost first, each with its position and
// a flag on the rightmost one, held in an output register under valid/ready
// leading positions are spaces, a minus sign sits just before the top digit of a
// negative value, zero gives one '0'; text wider than the field keeps its right end
// conversion runs one digit at a time through a shared divide-by-ten unit, each
// digit as a registered reciprocal multiply, then a remainder fix-up;
// every position is built before the characters are sent, and the sequencer
// returns to idle once the last character is loaded into the output register
// o_in_ready is high only in idle, so no new item is taken while one is still
// converting or sending; the first character is loaded into the output register
// once every position is built
// a receiver stall holds the output register and pauses the sender; the next item
// can be taken while the last character still waits in the output register
// reset (i_rst_n low, synchronous) returns to idle and drops any pending output
module signed_int_to_decimal_text #(
    parameter int FIELD_CHARS = 11,
    parameter int VALUE_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [VALUE_BITS-1:0] i_value,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [5:0]                   o_text_char,
    output logic [3:0]                   o_char_position,
    output logic                         o_last_char
);
    import sitdt_pkg::*;

    localparam int POS_W = $clog2(FIELD_CHARS);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FIELD_CHARS - 1);

    t_state r_state, n_state;

    logic [VALUE_BITS-1:0] r_mag;
    logic                  r_neg;
    logic                  r_first;
    logic [POS_W-1:0]      r_step;
    logic [POS_W-1:0]      r_pos;
    logic [5:0]            r_buf [FIELD_CHARS];

    logic                  r_out_valid;
    logic [5:0]            r_out_char;
    logic [3:0]            r_out_pos;
    logic                  r_out_last;

    logic                  in_accept;
    logic                  div_load;
    logic                  dig_step;
    logic                  emit_load;
    logic [VALUE_BITS-1:0] in_mag;
    logic [VALUE_BITS-1:0] quot;
    logic [3:0]            rem;
    logic [5:0]            new_char;

    sitdt_div10 #(
        .W(VALUE_BITS)
    ) u_div10 (
        .i_clk      (i_clk),
        .i_load     (div_load),
        .i_dividend (r_mag),
        .o_quotient (quot),
        .o_remainder(rem)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_MUL;
            end
            S_MUL:  n_state = S_DIG;
            S_DIG: begin
                n_state = (r_step == LAST_POS) ? S_EMIT : S_MUL;
            end
            S_EMIT: begin
                if (emit_load && r_pos == LAST_POS) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_ready = 1'b0;
        div_load   = 1'b0;
        dig_step   = 1'b0;
        emit_load  = 1'b0;
        unique case (r_state)
            S_IDLE: o_in_ready = 1'b1;
            S_MUL:  div_load   = 1'b1;
            S_DIG:  dig_step   = 1'b1;
            S_EMIT: emit_load  = !r_out_valid || i_out_ready;
            default: o_in_ready = 1'b0;
        endcase
    end

    assign in_accept = i_in_valid && o_in_ready;

    // unsigned magnitude, so the most negative value converts too
    assign in_mag = i_value[VALUE_BITS-1] ? (~i_value + 1'b1) : i_value;

    // character for this position: digit while value remains, then sign, then space
    always_comb begin
        if (r_mag != '0 || r_first) begin
            new_char = CH_ZERO + 6'(rem);
        end else if (r_neg) begin
            new_char = CH_MINUS;
        end else begin
            new_char = CH_SPACE;
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // conversion datapath: digits enter at the left and shift right
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_mag   <= in_mag;
            r_neg   <= i_value[VALUE_BITS-1];
            r_first <= 1'b1;
            r_step  <= '0;
        end else if (dig_step) begin
            r_mag   <= quot;
            r_first <= 1'b0;
            r_step  <= r_step + 1'b1;
            r_pos   <= '0;
            if (!(r_mag != '0 || r_first)) r_neg <= 1'b0;
            r_buf[0] <= new_char;
            for (int k = 1; k < FIELD_CHARS; k++) begin
                r_buf[k] <= r_buf[k-1];
            end
        end else if (emit_load) begin
            r_pos <= r_pos + 1'b1;
        end
    end

    // output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload, leftmost character first
    always_ff @(posedge i_clk) begin
        if (emit_load) begin
            r_out_char <= r_buf[r_pos];
            r_out_pos  <= 4'(r_pos);
            r_out_last <= (r_pos == LAST_POS);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_text_char     = r_out_char;
    assign o_char_position = r_out_pos;
    assign o_last_char     = r_out_last;

endmodule
